FILE: rtl/core/kvt_pkg.sv
// Shared types and constants for the linear key/value table.
package kvt_pkg;

  localparam int FUNC_W     = 2;
  localparam int KEY_PORT_W = 32;
  localparam int VAL_PORT_W = 32;
  localparam int CNT_PORT_W = 5;
  localparam int LIMIT_W    = 5;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd16;

  typedef enum logic [FUNC_W-1:0] {
    FN_ADD    = 2'd0,
    FN_REMOVE = 2'd1,
    FN_LOOKUP = 2'd2
  } func_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic                  ok;
    logic [VAL_PORT_W-1:0] found_value;
    logic [CNT_PORT_W-1:0] entry_count;
  } rsp_t;

endpackage

FILE: rtl/core/kvt_if.sv
// Channel interfaces: request, response and configuration write.
interface kvt_req_if import kvt_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [FUNC_W-1:0]     func;
  logic [KEY_PORT_W-1:0] key;
  logic [VAL_PORT_W-1:0] new_value;

  modport source(output valid, func, key, new_value, input ready);
  modport sink(input valid, func, key, new_value, output ready);
endinterface

interface kvt_rsp_if import kvt_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic                  ok;
  logic [VAL_PORT_W-1:0] found_value;
  logic [CNT_PORT_W-1:0] entry_count;

  modport source(output valid, ok, found_value, entry_count, input ready);
  modport sink(input valid, ok, found_value, entry_count, output ready);
endinterface

interface kvt_cfg_if import kvt_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [LIMIT_W-1:0] data;

  modport source(output valid, data, input ready);
  modport sink(input valid, data, output ready);
endinterface

FILE: rtl/core/kvt_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
module kvt_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/core/kvt_ctrl.sv
// Request sequencer: append, linear scan with read-compare, and tail compaction.
module kvt_ctrl import kvt_pkg::*; #(
  parameter int CAPACITY    = 16,
  parameter int KEY_WIDTH   = 32,
  parameter int VALUE_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  kvt_req_if.sink            req,
  input  logic [LIMIT_W-1:0] limit,
  output logic               rsp_valid,
  output rsp_t               rsp,
  input  logic               rsp_take
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int EW = KEY_WIDTH + VALUE_WIDTH;
  localparam int LW = (CW > LIMIT_W) ? CW : LIMIT_W;
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

  state_t                 state_r, state_nxt;
  logic [CW-1:0]          count_r, count_nxt;
  logic [CW-1:0]          cur_r, cur_nxt;
  logic [FUNC_W-1:0]      op_r, op_nxt;
  logic [KEY_WIDTH-1:0]   key_r, key_nxt;
  logic [VALUE_WIDTH-1:0] val_r, val_nxt;
  logic                   ok_r, ok_nxt;
  logic                   hit_r, hit_nxt;

  logic                   we, re;
  logic [IW-1:0]          waddr, raddr;
  logic [EW-1:0]          wdata, rdata;

  logic [KEY_WIDTH-1:0]   key_in;
  logic [VALUE_WIDTH-1:0] val_in;
  logic [KEY_WIDTH-1:0]   rd_key;
  logic [VALUE_WIDTH-1:0] rd_val;
  logic [CW-1:0]          cur_inc, cur_dec, count_dec;
  logic                   accept, room, last, match;

  kvt_ram #(
    .WIDTH(EW),
    .DEPTH(CAPACITY),
    .AW   (IW)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .re   (re),
    .raddr(raddr),
    .rdata(rdata)
  );

  assign req.ready = (state_r == ST_IDLE);
  assign accept    = req.valid && req.ready;
  assign key_in    = KEY_WIDTH'(req.key);
  assign val_in    = VALUE_WIDTH'(req.new_value);
  assign rd_key    = rdata[EW-1:VALUE_WIDTH];
  assign rd_val    = rdata[VALUE_WIDTH-1:0];
  assign cur_inc   = cur_r + CW'(1);
  assign cur_dec   = cur_r - CW'(1);
  assign count_dec = count_r - CW'(1);
  assign room      = (LW'(count_r) < LW'(limit)) && (count_r < CAP_C);
  assign last      = (cur_r == count_dec);
  assign match     = (rd_key == key_r);

  assign rsp_valid       = (state_r == ST_DONE);
  assign rsp.ok          = ok_r;
  assign rsp.found_value = VAL_PORT_W'(val_r);
  assign rsp.entry_count = CNT_PORT_W'(count_r);

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    cur_nxt   = cur_r;
    op_nxt    = op_r;
    key_nxt   = key_r;
    val_nxt   = val_r;
    ok_nxt    = ok_r;
    hit_nxt   = hit_r;
    we        = 1'b0;
    waddr     = count_r[IW-1:0];
    wdata     = {key_in, val_in};
    re        = 1'b0;
    raddr     = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          op_nxt  = req.func;
          key_nxt = key_in;
          val_nxt = '0;
          ok_nxt  = 1'b0;
          hit_nxt = 1'b0;
          cur_nxt = '0;
          state_nxt = ST_DONE;
          case (req.func) inside
            FN_ADD: begin
              if (room) begin
                we        = 1'b1;
                count_nxt = count_r + CW'(1);
                ok_nxt    = 1'b1;
              end
            end
            FN_REMOVE, FN_LOOKUP: begin
              if (count_r != '0) begin
                re        = 1'b1;
                state_nxt = ST_SCAN;
              end
            end
            default: ;
          endcase
        end
      end
      ST_SCAN: begin
        re      = !last;
        raddr   = cur_inc[IW-1:0];
        cur_nxt = cur_inc;
        if (hit_r) begin
          we    = 1'b1;
          waddr = cur_dec[IW-1:0];
          wdata = rdata;
        end
        if (op_r == FN_LOOKUP && match) begin
          ok_nxt    = 1'b1;
          val_nxt   = rd_val;
          state_nxt = ST_DONE;
        end else if (last) begin
          if (hit_r || match) begin
            count_nxt = count_dec;
            ok_nxt    = 1'b1;
          end
          state_nxt = ST_DONE;
        end else if (match) begin
          hit_nxt = 1'b1;
        end
      end
      ST_DONE: begin
        if (rsp_take) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
    op_r  <= op_nxt;
    key_r <= key_nxt;
    val_r <= val_nxt;
    ok_r  <= ok_nxt;
    hit_r <= hit_nxt;
  end

endmodule

FILE: rtl/core/linear_key_value_table_unit.sv
// Top level of the linear key/value table: config register, sequencer, output register.
//
// Requests arrive on in_ch (func, key, new_value) with valid/ready; one result
// beat (ok, found_value, entry_count) leaves on out_ch for every request beat.
// func: add appends the pair if the table holds fewer entries than the smaller
// of the limit register and CAPACITY; remove deletes the first matching entry
// and moves later entries down; lookup returns the value of the first match.
// cfg_ch writes the 5-bit entry limit; write it only while no request is open.
// An add, an unused func code, or a remove/lookup on an empty table goes from
// idle straight to the result state. A remove or lookup reads one entry per cycle
// through the single registered read port of the entry RAM: a lookup stops at
// its first hit, while a miss or any remove scans every entry held. The sequencer
// takes one request at a time; the output register may still hold an earlier beat.
// Reset empties the table (entry count 0; RAM contents are not cleared) and
// sets the limit to 16. A stalled out_ch holds its beat in the output register;
// the sequencer finishes its next request and then waits for that register.
module linear_key_value_table_unit import kvt_pkg::*; #(
  parameter int CAPACITY    = 16,
  parameter int KEY_WIDTH   = 32,
  parameter int VALUE_WIDTH = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  kvt_req_if.sink   in_ch,
  kvt_rsp_if.source out_ch,
  kvt_cfg_if.sink   cfg_ch
);

  logic [LIMIT_W-1:0] limit_r;
  logic               out_valid_r;
  rsp_t               out_rsp_r;
  logic               rsp_valid;
  rsp_t               rsp;
  logic               rsp_take;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= LIMIT_RESET;
    end else if (cfg_ch.valid) begin
      limit_r <= cfg_ch.data;
    end
  end

  kvt_ctrl #(
    .CAPACITY   (CAPACITY),
    .KEY_WIDTH  (KEY_WIDTH),
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (in_ch),
    .limit    (limit_r),
    .rsp_valid(rsp_valid),
    .rsp      (rsp),
    .rsp_take (rsp_take)
  );

  assign rsp_take = rsp_valid && (!out_valid_r || out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (rsp_take) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_take) begin
      out_rsp_r <= rsp;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.ok          = out_rsp_r.ok;
  assign out_ch.found_value = out_rsp_r.found_value;
  assign out_ch.entry_count = out_rsp_r.entry_count;

endmodule

FILE: tb/linear_key_value_table_unit_tb.sv
// Self-checking testbench for the linear key/value table: directed and random traffic, scoreboard.
module linear_key_value_table_unit_tb import kvt_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = 16;
  localparam int RANDOM_PER_BATCH = 86;
  localparam int POOL_SIZE = 6;
  localparam logic [FUNC_W-1:0] FN_UNUSED = 2'd3;

  logic clk = 1'b0;
  logic rst_n;

  kvt_req_if req_bus();
  kvt_rsp_if rsp_bus();
  kvt_cfg_if cfg_bus();

  linear_key_value_table_unit uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (req_bus),
    .out_ch (rsp_bus),
    .cfg_ch (cfg_bus)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // table model
  logic [KEY_PORT_W-1:0] tbl_key [DEPTH];
  logic [VAL_PORT_W-1:0] tbl_val [DEPTH];
  int                    tbl_count;
  logic [LIMIT_W-1:0]    tbl_limit;
  rsp_t                  rsp_expected [$];

  int send_idle_pct;
  int recv_stall_pct;
  int err_count;
  int n_requests;
  int n_results;
  int n_hits;
  int n_refused;

  function automatic rsp_t table_apply(input logic [FUNC_W-1:0] fn,
                                       input logic [KEY_PORT_W-1:0] k,
                                       input logic [VAL_PORT_W-1:0] v);
    rsp_t r;
    int   lim;
    int   hit;
    r   = '0;
    lim = (tbl_limit < DEPTH) ? int'(tbl_limit) : DEPTH;
    hit = -1;
    for (int i = 0; i < tbl_count; i++) begin
      if (hit < 0 && tbl_key[i] == k) hit = i;
    end
    case (fn)
      FN_ADD: begin
        if (tbl_count < lim) begin
          tbl_key[tbl_count] = k;
          tbl_val[tbl_count] = v;
          tbl_count++;
          r.ok = 1'b1;
        end else begin
          n_refused++;
        end
      end
      FN_REMOVE: begin
        if (hit >= 0) begin
          for (int i = hit; i < tbl_count - 1; i++) begin
            tbl_key[i] = tbl_key[i + 1];
            tbl_val[i] = tbl_val[i + 1];
          end
          tbl_count--;
          r.ok = 1'b1;
        end
      end
      FN_LOOKUP: begin
        if (hit >= 0) begin
          r.ok          = 1'b1;
          r.found_value = tbl_val[hit];
          n_hits++;
        end
      end
      default: ;
    endcase
    r.entry_count = tbl_count[CNT_PORT_W-1:0];
    return r;
  endfunction

  task automatic report_mismatch(input string what, input longint want, input longint got);
    $display("[%0t] mismatch on result %0d, %s: expected %0h, got %0h",
             $realtime, n_results, what, want, got);
    err_count++;
  endtask

  // result beats
  always @(posedge clk) begin
    rsp_t want;
    if (rst_n && rsp_bus.valid && rsp_bus.ready) begin
      if (rsp_expected.size() == 0) begin
        report_mismatch("unexpected beat", 0, rsp_bus.found_value);
      end else begin
        want = rsp_expected.pop_front();
        if (rsp_bus.ok !== want.ok) report_mismatch("ok", want.ok, rsp_bus.ok);
        if (rsp_bus.found_value !== want.found_value)
          report_mismatch("found_value", want.found_value, rsp_bus.found_value);
        if (rsp_bus.entry_count !== want.entry_count)
          report_mismatch("entry_count", want.entry_count, rsp_bus.entry_count);
      end
      n_results++;
    end
  end

  always @(negedge clk) begin
    rsp_bus.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  task automatic send_req(input logic [FUNC_W-1:0] fn, input logic [KEY_PORT_W-1:0] k,
                          input logic [VAL_PORT_W-1:0] v);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      req_bus.valid <= 1'b0;
      @(negedge clk);
    end
    req_bus.valid     <= 1'b1;
    req_bus.func      <= fn;
    req_bus.key       <= k;
    req_bus.new_value <= v;
    @(posedge clk);
    while (!req_bus.ready) @(posedge clk);
    rsp_expected.push_back(table_apply(fn, k, v));
    n_requests++;
    @(negedge clk);
  endtask

  task automatic wait_idle();
    req_bus.valid <= 1'b0;
    while (rsp_expected.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_limit(input logic [LIMIT_W-1:0] lim);
    wait_idle();
    cfg_bus.valid <= 1'b1;
    cfg_bus.data  <= lim;
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
    tbl_limit = lim;
    @(negedge clk);
    cfg_bus.valid <= 1'b0;
  endtask

  task automatic test_empty_table();
    send_req(FN_LOOKUP, 32'h0000_0000, 32'hFFFF_FFFF);
    send_req(FN_REMOVE, 32'hFFFF_FFFF, 32'h0000_0000);
    send_req(FN_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    wait_idle();
  endtask

  task automatic test_first_match_and_shift();
    send_req(FN_ADD,    32'h0000_0000, 32'hFFFF_FFFF);
    send_req(FN_ADD,    32'hFFFF_FFFF, 32'h0000_0000);
    send_req(FN_ADD,    32'h0000_0000, 32'h1234_5678);
    send_req(FN_LOOKUP, 32'h0000_0000, 32'h0);
    send_req(FN_LOOKUP, 32'hFFFF_FFFF, 32'h0);
    send_req(FN_REMOVE, 32'h0000_0000, 32'h0);
    send_req(FN_LOOKUP, 32'h0000_0000, 32'h0);
    send_req(FN_REMOVE, 32'h0000_0005, 32'h0);
    send_req(FN_UNUSED, 32'h0000_0000, 32'hA5A5_A5A5);
    send_req(FN_REMOVE, 32'hFFFF_FFFF, 32'h0);
    send_req(FN_REMOVE, 32'h0000_0000, 32'h0);
    wait_idle();
  endtask

  task automatic test_capacity_limit();
    write_limit(5'd2);
    send_req(FN_ADD, 32'h0000_00AA, 32'h0000_0001);
    send_req(FN_ADD, 32'h0000_00BB, 32'h0000_0002);
    send_req(FN_ADD, 32'h0000_00CC, 32'h0000_0003);
    // limit dropped below contents: entries stay, adds refused
    write_limit(5'd0);
    send_req(FN_ADD,    32'h0000_00DD, 32'h0000_0004);
    send_req(FN_LOOKUP, 32'h0000_00BB, 32'h0);
    write_limit(5'd1);
    send_req(FN_REMOVE, 32'h0000_00AA, 32'h0);
    send_req(FN_ADD,    32'h0000_00DD, 32'h0000_0004);
    send_req(FN_REMOVE, 32'h0000_00BB, 32'h0);
    send_req(FN_ADD,    32'h0000_00DD, 32'h0000_0005);
    send_req(FN_REMOVE, 32'h0000_00DD, 32'h0);
    write_limit(5'd15);
    write_limit(LIMIT_RESET);
  endtask

  task automatic test_random_traffic();
    logic [KEY_PORT_W-1:0] pool [POOL_SIZE];
    logic [FUNC_W-1:0]     fn;
    logic [KEY_PORT_W-1:0] k;
    logic [LIMIT_W-1:0]    lim;
    int                    add_pct;
    int                    roll;
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 71; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 71; end
        default: begin send_idle_pct = 38; recv_stall_pct = 38; end
      endcase
      for (int batch = 0; batch < 4; batch++) begin
        case (batch)
          0, 2:    lim = LIMIT_RESET;
          1:       lim = LIMIT_W'($urandom_range(1, 15));
          default: lim = (phase % 2 == 0) ? 5'd0 : LIMIT_W'($urandom_range(1, 15));
        endcase
        write_limit(lim);
        pool[0] = '0;
        pool[1] = '1;
        for (int i = 2; i < POOL_SIZE; i++) pool[i] = $urandom();
        add_pct = (batch % 2 == 0) ? 60 : 30;
        repeat (RANDOM_PER_BATCH) begin
          roll = $urandom_range(0, 99);
          if (roll < add_pct) fn = FN_ADD;
          else if (roll < add_pct + (95 - add_pct) / 2) fn = FN_REMOVE;
          else if (roll < 95) fn = FN_LOOKUP;
          else fn = FN_UNUSED;
          if ($urandom_range(0, 99) < 85) k = pool[$urandom_range(0, POOL_SIZE - 1)];
          else k = $urandom();
          send_req(fn, k, $urandom());
        end
      end
    end
    wait_idle();
  endtask

  initial begin
    rst_n             = 1'b0;
    req_bus.valid     = 1'b0;
    req_bus.func      = '0;
    req_bus.key       = '0;
    req_bus.new_value = '0;
    rsp_bus.ready     = 1'b0;
    cfg_bus.valid     = 1'b0;
    cfg_bus.data      = '0;
    send_idle_pct     = 0;
    recv_stall_pct    = 0;
    err_count         = 0;
    n_requests        = 0;
    n_results         = 0;
    n_hits            = 0;
    n_refused         = 0;
    tbl_count         = 0;
    tbl_limit         = LIMIT_RESET;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_empty_table();
    test_first_match_and_shift();
    test_capacity_limit();
    test_random_traffic();

    repeat (30) @(negedge clk);
    if (rsp_expected.size() != 0)
      report_mismatch("results still missing", rsp_expected.size(), 0);
    $display("run covered %0d requests and %0d result beats under four idle/stall mixes",
             n_requests, n_results);
    $display("lookup hits %0d, adds refused at the limit %0d, mismatches %0d",
             n_hits, n_refused, err_count);
    if (err_count == 0) begin
      $display("linear_key_value_table_unit_tb: PASS");
    end else begin
      $display("linear_key_value_table_unit_tb: FAIL");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("timeout after %0d requests, %0d results", n_requests, n_results);
    $display("linear_key_value_table_unit_tb: FAIL");
    $finish;
  end

endmodule
